>>> rtl/b64lw_pkg.sv
// Shared types, constants and the alphabet lookup of the base64 line-wrap encoder.
`default_nettype none

package b64lw_pkg;

  // Field and counter widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned WidthW   = 8;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned JobChars = 4;
  localparam int unsigned JobIdxW  = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLineWidth   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgOutputLimit = 1'b1;

  // Register reset values
  localparam logic [WidthW-1:0] LineWidthRst   = 8'd0;
  localparam logic [LimitW-1:0] OutputLimitRst = 16'hFFFF;

  // Special characters
  localparam logic [ByteW-1:0] CharPad     = 8'h3D;
  localparam logic [ByteW-1:0] CharNewline = 8'h0A;

  // Left-over bit counts
  localparam logic [2:0] ResNone = 3'd0;
  localparam logic [2:0] ResTwo  = 3'd2;
  localparam logic [2:0] ResFour = 3'd4;

  // One accepted byte, expanded to its encoded characters (newlines not yet inserted)
  typedef struct packed {
    logic [JobChars-1:0][ByteW-1:0] chars;
    logic [JobIdxW-1:0]             last_idx;
    logic                           last;
  } job_t;

  // Map a six-bit group to its base64 character
  function automatic logic [ByteW-1:0] b64_char(input logic [5:0] v);
    logic [ByteW-1:0] w;
    begin
      w = {2'b00, v};
      if (v < 6'd26) begin
        b64_char = w + 8'h41;
      end else if (v < 6'd52) begin
        b64_char = w + 8'h61 - 8'd26;
      end else if (v < 6'd62) begin
        b64_char = w + 8'h30 - 8'd52;
      end else if (v == 6'd62) begin
        b64_char = 8'h2B;
      end else begin
        b64_char = 8'h2F;
      end
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/base64_encoder_line_wrap.sv
// Top level of the streaming base64 encoder with line wrapping and an output limit.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   in      | input     | in_valid_i/in_stall_o | data_byte_i, last_byte_i
//   out     | output    | out_valid_o/out_stall_i| character_o, run_end_o, message_end_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A byte is expanded into one to four characters in the cycle it is accepted and
// parked in a one-entry holding register, from which it moves on to the emitter; a new
// byte is taken only while the holding register is empty. The emitter then produces one
// result (character or newline) per cycle while the output is not stalled, and drops a
// byte whose characters all fall past the limit without a result; a byte passes from the
// holding register to the active job and then to the output register. Reset
// clears all counters and valids; config registers return to width 0 and limit 65535.
// A stalled output freezes the emitter, and the input stalls once the holding
// register is full.
`default_nettype none

module base64_encoder_line_wrap (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input channel
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [b64lw_pkg::ByteW-1:0]       data_byte_i,
  input  wire                               last_byte_i,
  // output channel
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [b64lw_pkg::ByteW-1:0]       character_o,
  output logic                              run_end_o,
  output logic                              message_end_o,
  // configuration channel
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [b64lw_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire  [b64lw_pkg::CfgDataW-1:0]    cfg_data_i
);

  // Configuration registers
  logic [b64lw_pkg::WidthW-1:0] line_width_q;
  logic [b64lw_pkg::LimitW-1:0] output_limit_q;

  // Left-over bits
  logic [3:0] res_bits_q, res_bits_d;
  logic [2:0] res_cnt_q, res_cnt_d;

  // Holding register and active job
  b64lw_pkg::job_t               pend_q, job_d, act_q;
  logic                          pend_valid_q;
  logic                          act_valid_q;
  logic [b64lw_pkg::JobIdxW-1:0] act_idx_q, act_idx_d;
  logic                          act_nl_q, act_nl_d;

  // Line and message counters
  logic [b64lw_pkg::WidthW-1:0] col_q, col_d;
  logic [b64lw_pkg::LimitW-1:0] emitted_q, emitted_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic [b64lw_pkg::ByteW-1:0]  out_char_q, out_char_d;
  logic                         out_run_end_q, out_run_end_d;
  logic                         out_msg_end_q, out_msg_end_d;

  logic in_accept;
  logic step;
  logic skip;
  logic done;
  logic nl_next;
  logic act_load;
  logic [b64lw_pkg::LimitW-1:0] emitted_inc;
  logic [b64lw_pkg::WidthW-1:0] col_inc;
  logic at_last_char;
  logic limit_hit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = pend_valid_q;
  assign in_accept   = in_valid_i && !pend_valid_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= b64lw_pkg::LineWidthRst;
      output_limit_q <= b64lw_pkg::OutputLimitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        b64lw_pkg::CfgLineWidth:   line_width_q   <= cfg_data_i[b64lw_pkg::WidthW-1:0];
        b64lw_pkg::CfgOutputLimit: output_limit_q <= cfg_data_i[b64lw_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Expand the incoming byte into characters and advance the left-over bits
  always_comb begin
    job_d       = '0;
    job_d.last  = last_byte_i;
    res_bits_d  = res_bits_q;
    res_cnt_d   = res_cnt_q;
    case (res_cnt_q)
      b64lw_pkg::ResNone: begin
        job_d.chars[0]  = b64lw_pkg::b64_char(data_byte_i[7:2]);
        job_d.last_idx  = 2'd0;
        res_bits_d      = {2'b00, data_byte_i[1:0]};
        res_cnt_d       = b64lw_pkg::ResTwo;
        if (last_byte_i) begin
          job_d.chars[1] = b64lw_pkg::b64_char({data_byte_i[1:0], 4'b0000});
          job_d.chars[2] = b64lw_pkg::CharPad;
          job_d.chars[3] = b64lw_pkg::CharPad;
          job_d.last_idx = 2'd3;
        end
      end
      b64lw_pkg::ResTwo: begin
        job_d.chars[0]  = b64lw_pkg::b64_char({res_bits_q[1:0], data_byte_i[7:4]});
        job_d.last_idx  = 2'd0;
        res_bits_d      = data_byte_i[3:0];
        res_cnt_d       = b64lw_pkg::ResFour;
        if (last_byte_i) begin
          job_d.chars[1] = b64lw_pkg::b64_char({data_byte_i[3:0], 2'b00});
          job_d.chars[2] = b64lw_pkg::CharPad;
          job_d.last_idx = 2'd2;
        end
      end
      default: begin
        job_d.chars[0]  = b64lw_pkg::b64_char({res_bits_q, data_byte_i[7:6]});
        job_d.chars[1]  = b64lw_pkg::b64_char(data_byte_i[5:0]);
        job_d.last_idx  = 2'd1;
        res_bits_d      = 4'd0;
        res_cnt_d       = b64lw_pkg::ResNone;
      end
    endcase
    if (last_byte_i) begin
      res_bits_d = 4'd0;
      res_cnt_d  = b64lw_pkg::ResNone;
    end
  end

  // Hold left-over bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bits_q <= 4'd0;
      res_cnt_q  <= b64lw_pkg::ResNone;
    end else if (in_accept) begin
      res_bits_q <= res_bits_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

  // Emitter step: one character or newline per cycle while the output is not stalled
  always_comb begin
    step         = act_valid_q && (!out_valid_q || !out_stall_i);
    emitted_inc  = emitted_q + 16'd1;
    col_inc      = col_q + 8'd1;
    at_last_char = (act_idx_q == act_q.last_idx);
    limit_hit    = (emitted_inc >= output_limit_q);
    skip         = !act_nl_q && (emitted_q >= output_limit_q);
    nl_next      = !act_nl_q && !skip && (line_width_q != 8'd0)
                   && (col_inc >= line_width_q) && !limit_hit;
    done         = skip || nl_next ? skip : (at_last_char || limit_hit);

    col_d         = col_q;
    emitted_d     = emitted_q;
    act_idx_d     = act_idx_q;
    act_nl_d      = act_nl_q;
    out_char_d    = out_char_q;
    out_run_end_d = out_run_end_q;
    out_msg_end_d = out_msg_end_q;
    out_valid_d   = out_valid_q && out_stall_i;

    if (step && !skip) begin
      out_valid_d   = 1'b1;
      out_char_d    = act_nl_q ? b64lw_pkg::CharNewline : act_q.chars[act_idx_q];
      out_run_end_d = done;
      out_msg_end_d = done && act_q.last;
      emitted_d     = emitted_inc;
      if (act_nl_q) begin
        col_d    = 8'd0;
        act_nl_d = 1'b0;
        act_idx_d = act_idx_q + 2'd1;
      end else begin
        if (line_width_q != 8'd0) begin
          col_d = col_inc;
        end
        if (nl_next) begin
          act_nl_d = 1'b1;
        end else begin
          act_idx_d = act_idx_q + 2'd1;
        end
      end
    end

    // Clear the message counters once the last byte is through
    if (step && done && act_q.last) begin
      col_d     = 8'd0;
      emitted_d = 16'd0;
    end

    act_load = pend_valid_q && (!act_valid_q || (step && done));
    if (act_load || (step && done)) begin
      act_idx_d = '0;
      act_nl_d  = 1'b0;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      act_valid_q  <= 1'b0;
      act_idx_q    <= '0;
      act_nl_q     <= 1'b0;
      col_q        <= 8'd0;
      emitted_q    <= 16'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_accept) begin
        pend_valid_q <= 1'b1;
      end else if (act_load) begin
        pend_valid_q <= 1'b0;
      end
      if (act_load) begin
        act_valid_q <= 1'b1;
      end else if (step && done) begin
        act_valid_q <= 1'b0;
      end
      act_idx_q   <= act_idx_d;
      act_nl_q    <= act_nl_d;
      col_q       <= col_d;
      emitted_q   <= emitted_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pend_q <= job_d;
    end
    if (act_load) begin
      act_q <= pend_q;
    end
    out_char_q    <= out_char_d;
    out_run_end_q <= out_run_end_d;
    out_msg_end_q <= out_msg_end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign character_o   = out_char_q;
  assign run_end_o     = out_run_end_q;
  assign message_end_o = out_msg_end_q;

endmodule

`default_nettype wire

>>> bench/base64_char_checker.sv
// Checker for the base64 line-wrap encoder: predicts the character stream and compares it.
module base64_char_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [b64lw_pkg::ByteW-1:0]    data_byte_i,
  input  logic                           last_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [b64lw_pkg::ByteW-1:0]    character_i,
  input  logic                           run_end_i,
  input  logic                           message_end_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [b64lw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [b64lw_pkg::CfgDataW-1:0] cfg_data_i,
  output int                             pending_o,
  output int                             fail_count_o
);

  typedef struct packed {
    logic [b64lw_pkg::ByteW-1:0] ch;
    logic                        run_end;
    logic                        msg_end;
  } b64_out_t;

  string sym_table = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Shadow configuration and encoder state
  logic [b64lw_pkg::WidthW-1:0] width_reg = b64lw_pkg::LineWidthRst;
  logic [b64lw_pkg::LimitW-1:0] limit_reg = b64lw_pkg::OutputLimitRst;
  logic [3:0]        res_bits  = '0;
  int                res_cnt   = 0;
  logic [7:0]        col_cnt   = '0;
  logic [15:0]       sent_cnt  = '0;

  b64_out_t char_queue[$];
  b64_out_t step_chars[$];
  b64_out_t want;
  int       mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Append one character unless the message limit is reached; wrap the line when full
  function automatic void emit_char(input logic [b64lw_pkg::ByteW-1:0] ch);
    if (sent_cnt >= limit_reg) return;
    step_chars.push_back('{ch: ch, run_end: 1'b0, msg_end: 1'b0});
    sent_cnt = sent_cnt + 16'd1;
    if (width_reg != '0) begin
      col_cnt = col_cnt + 8'd1;
      // drop the newline when it would go past the limit, and keep the column
      if (col_cnt >= width_reg && sent_cnt < limit_reg) begin
        step_chars.push_back('{ch: b64lw_pkg::CharNewline, run_end: 1'b0, msg_end: 1'b0});
        sent_cnt = sent_cnt + 16'd1;
        col_cnt  = '0;
      end
    end
  endfunction

  // Encode one accepted byte and queue the characters it produces
  function automatic void encode_byte(input logic [b64lw_pkg::ByteW-1:0] data,
                                      input logic last);
    logic [11:0] acc;
    int          bits;
    int          pad;
    logic [5:0]  tail;
    b64_out_t    final_out;
    step_chars.delete();
    acc  = {res_bits, data};
    bits = res_cnt + 8;
    while (bits >= 6) begin
      bits -= 6;
      emit_char(sym_table[int'((acc >> bits) & 12'h03F)]);
    end
    res_bits = 4'(acc & ((12'd1 << bits) - 12'd1));
    res_cnt  = bits;
    // flush the left-over bits zero-padded, then pad to a multiple of four
    if (last) begin
      pad = 0;
      if (bits != 0) begin
        tail = 6'({2'b00, res_bits} << (6 - bits));
        emit_char(sym_table[int'(tail)]);
        pad = (bits == 2) ? 2 : 1;
      end
      repeat (pad) emit_char(b64lw_pkg::CharPad);
      res_bits = '0;
      res_cnt  = 0;
      col_cnt  = '0;
      sent_cnt = '0;
    end
    // flag the final character of this byte, and of the message on the last byte
    if (step_chars.size() > 0) begin
      final_out         = step_chars.pop_back();
      final_out.run_end = 1'b1;
      final_out.msg_end = last;
      step_chars.push_back(final_out);
    end
    foreach (step_chars[k]) char_queue.push_back(step_chars[k]);
  endfunction

  // Track configuration, predict on accepted bytes, compare accepted characters
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = b64lw_pkg::LineWidthRst;
      limit_reg = b64lw_pkg::OutputLimitRst;
      res_bits  = '0;
      res_cnt   = 0;
      col_cnt   = '0;
      sent_cnt  = '0;
      char_queue.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == b64lw_pkg::CfgLineWidth) begin
          width_reg = cfg_data_i[b64lw_pkg::WidthW-1:0];
        end else if (cfg_index_i == b64lw_pkg::CfgOutputLimit) begin
          limit_reg = cfg_data_i[b64lw_pkg::LimitW-1:0];
        end
      end
      if (in_valid_i && !in_stall_i) begin
        encode_byte(data_byte_i, last_byte_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (char_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h", character_i));
        end else begin
          want = char_queue.pop_front();
          if (character_i !== want.ch) begin
            report_mismatch($sformatf("character 0x%02h, want 0x%02h", character_i, want.ch));
          end
          if (run_end_i !== want.run_end) begin
            report_mismatch($sformatf("run_end %b, want %b (char 0x%02h)",
                                      run_end_i, want.run_end, want.ch));
          end
          if (message_end_i !== want.msg_end) begin
            report_mismatch($sformatf("message_end %b, want %b (char 0x%02h)",
                                      message_end_i, want.msg_end, want.ch));
          end
        end
      end
      pending_o <= char_queue.size();
    end
  end

endmodule

>>> bench/tb_base64_encoder_line_wrap.sv
// Testbench top for the base64 line-wrap encoder: stimulus, stalls and the verdict.
module tb_base64_encoder_line_wrap;

  localparam int HalfPeriod = 5;
  localparam int SettleCycles = 24;
  localparam int TimeoutUnits = 10_000_000;
  localparam int ItemTarget = 430;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [b64lw_pkg::ByteW-1:0]    data_byte = '0;
  logic                           last_byte = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [b64lw_pkg::ByteW-1:0]    character;
  logic                           run_end;
  logic                           message_end;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [b64lw_pkg::CfgIdxW-1:0]  cfg_index = b64lw_pkg::CfgLineWidth;
  logic [b64lw_pkg::CfgDataW-1:0] cfg_data = '0;
  int                             pending;
  int                             fail_count;

  int   items_sent = 0;
  logic quiet_in = 1'b0;
  int   stall_hold = 0;
  int   stall_pick;

  base64_encoder_line_wrap u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .last_byte_i  (last_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .character_o  (character),
    .run_end_o    (run_end),
    .message_end_o(message_end),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  base64_char_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .data_byte_i  (data_byte),
    .last_byte_i  (last_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .character_i  (character),
    .run_end_i    (run_end),
    .message_end_i(message_end),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Free-running clock
  always #(HalfPeriod) clk = ~clk;

  // Hold reset low at the start of the run and release it once
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stall the output: mostly short bursts, a few long ones, some quiet stretches
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 3);
      end else if (stall_pick < 90) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (stall_pick < 95) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(8, 40);
      end else begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(60, 250);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet_in) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one byte and hold it until accepted; keep valid high for back-to-back bytes
  task automatic send_byte(input logic [b64lw_pkg::ByteW-1:0] data, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= data;
    last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Stop sending, wait for every expected character, then let the pipeline settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write both registers in one back-to-back transaction pair
  task automatic write_config(input logic [b64lw_pkg::WidthW-1:0] width,
                              input logic [b64lw_pkg::LimitW-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= b64lw_pkg::CfgLineWidth;
    cfg_data  <= {8'($urandom), width};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= b64lw_pkg::CfgOutputLimit;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Main stimulus
  initial begin
    logic [b64lw_pkg::WidthW-1:0] width;
    logic [b64lw_pkg::LimitW-1:0] limit;
    int                burst;
    int                odds;
    int                pick;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // one, two, three and four byte messages; '+' and '/' symbols
    write_config(8'd0, 16'hFFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_and_settle();

    // wrap every four characters, padding included
    write_config(8'd4, 16'hFFFF);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h79, 1'b0);
    send_byte(8'h21, 1'b1);
    drain_and_settle();

    // limit hit: newline dropped, last byte truncated to nothing
    write_config(8'd2, 16'd2);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h33, 1'b1);
    drain_and_settle();

    // zero limit emits nothing
    write_config(8'd0, 16'd0);
    send_byte(8'h7E, 1'b1);
    drain_and_settle();

    // width lowered mid-line, then limit lowered below the count mid-message
    write_config(8'd8, 16'hFFFF);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    drain_and_settle();
    write_config(8'd3, 16'hFFFF);
    send_byte(8'h78, 1'b0);
    drain_and_settle();
    write_config(8'd0, 16'd2);
    send_byte(8'h9A, 1'b1);
    drain_and_settle();

    // one message long enough to wrap at the widest line
    write_config(8'd255, 16'hFFFF);
    repeat (191) send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);

    // random phases; a message may run across a configuration change
    while (items_sent < ItemTarget) begin
      drain_and_settle();
      pick = $urandom_range(0, 7);
      case (pick)
        0: width = 8'd0;
        1: width = 8'd1;
        2: width = 8'd255;
        3, 4: width = 8'($urandom_range(2, 8));
        default: width = 8'($urandom_range(0, 80));
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0: limit = 16'd0;
        1, 2: limit = 16'($urandom_range(1, 24));
        3: limit = 16'($urandom);
        default: limit = 16'hFFFF;
      endcase
      write_config(width, limit);
      quiet_in = ($urandom_range(0, 3) == 0);
      odds  = $urandom_range(2, 12);
      burst = $urandom_range(6, 30);
      repeat (burst) send_byte(8'($urandom), $urandom_range(1, odds) == 1);
    end
    drain_and_settle();

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #(TimeoutUnits);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/b64lw_pkg.sv
rtl/base64_encoder_line_wrap.sv
bench/base64_char_checker.sv
bench/tb_base64_encoder_line_wrap.sv
